// ----- sv/gql_pkg.sv -----
// ----------------------------------------------------------------------------
// gql_pkg
// Shared types, constants and saturation helpers of the glyph quad layout
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package gql_pkg;

  // defaults of the top-level parameters
  localparam int DEF_MAX_QUADS     = 1024;
  localparam int DEF_GLYPH_ENTRIES = 256;

  // fixed field widths
  localparam int CODE_W   = 8;
  localparam int ATLAS_W  = 12;
  localparam int QNUM_W   = 10;
  localparam int FIX_W    = 32;
  localparam int UV_W     = 24;
  localparam int SCALE_W  = 16;
  localparam int LAYER_W  = 16;
  localparam int ENTRY_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // width of the Q16.16 sums ahead of saturation
  localparam int SUM_W    = 36;
  // width of the UV sums ahead of saturation
  localparam int UVSUM_W  = 37;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // register reset values
  localparam logic [SCALE_W-1:0] RST_GLYPH_SCALE = 16'd256;
  localparam logic [UV_W-1:0]    RST_INV_ATLAS   = 24'd4096;
  localparam logic [31:0]        RST_TEXT_COLOR  = 32'hFFFF_FFFF;
  localparam logic [31:0]        ALPHA_FULL      = 32'h0000_00FF;

  // corner codes
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_START = 2'd3
  } gql_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_SCALE     = 3'd2,
    CFG_INV_W     = 3'd3,
    CFG_INV_H     = 3'd4,
    CFG_COLOR     = 3'd5,
    CFG_LAYER     = 3'd6
  } gql_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PUSH
  } gql_state_t;

  typedef struct packed {
    logic [FIX_W-1:0]   origin_x;
    logic [FIX_W-1:0]   origin_y;
    logic [SCALE_W-1:0] glyph_scale;
    logic [UV_W-1:0]    inv_atlas_width;
    logic [UV_W-1:0]    inv_atlas_height;
    logic [31:0]        text_color;
    logic [LAYER_W-1:0] layer_value;
  } gql_cfg_t;

  // one placed quad, as handed from front to back
  typedef struct packed {
    logic [QNUM_W-1:0] quad;
    logic [FIX_W-1:0]  x0;
    logic [FIX_W-1:0]  y0;
    logic [FIX_W-1:0]  x1;
    logic [FIX_W-1:0]  y1;
    logic [UV_W-1:0]   u0;
    logic [UV_W-1:0]   v0;
    logic [UV_W-1:0]   u1;
    logic [UV_W-1:0]   v1;
    logic [FIX_W-1:0]  px;
    logic [FIX_W-1:0]  py;
  } gql_quad_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gql_qstat_t;

  // sign-extend a Q16.16 word to the sum width
  function automatic logic [SUM_W-1:0] ext32(input logic [FIX_W-1:0] v);
    return {{(SUM_W-FIX_W){v[FIX_W-1]}}, v};
  endfunction

  // clamp a sum to the signed 32-bit range
  function automatic logic [FIX_W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic all_one;
    logic any_one;
    all_one = &v[SUM_W-1:FIX_W-1];
    any_one = |v[SUM_W-1:FIX_W-1];
    if (v[SUM_W-1] && !all_one) begin
      return {1'b1, {(FIX_W-1){1'b0}}};
    end else if (!v[SUM_W-1] && any_one) begin
      return {1'b0, {(FIX_W-1){1'b1}}};
    end else begin
      return v[FIX_W-1:0];
    end
  endfunction

  // clamp an unsigned UV sum at all ones
  function automatic logic [UV_W-1:0] sat24(input logic [UVSUM_W-1:0] v);
    return (|v[UVSUM_W-1:UV_W]) ? {UV_W{1'b1}} : v[UV_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/gql_ifs.sv -----
// ----------------------------------------------------------------------------
// gql_ifs
// Valid/ready channels of the glyph quad layout block: request, vertex and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gql_req_if import gql_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [CODE_W-1:0]         char_code;
  logic [7:0]                glyph_width;
  logic [7:0]                glyph_height;
  logic signed [7:0]         bearing_x;
  logic signed [7:0]         bearing_y;
  logic [7:0]                advance_px;
  logic [ATLAS_W-1:0]        atlas_x;
  logic [ATLAS_W-1:0]        atlas_y;

  modport source (output valid, req_type, char_code, glyph_width, glyph_height,
                  bearing_x, bearing_y, advance_px, atlas_x, atlas_y,
                  input ready);
  modport sink   (input valid, req_type, char_code, glyph_width, glyph_height,
                  bearing_x, bearing_y, advance_px, atlas_x, atlas_y,
                  output ready);
endinterface

interface gql_vtx_if import gql_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [QNUM_W-1:0]         quad_number;
  logic [1:0]                corner;
  logic signed [FIX_W-1:0]   vert_x;
  logic signed [FIX_W-1:0]   vert_y;
  logic [UV_W-1:0]           tex_u;
  logic [UV_W-1:0]           tex_v;
  logic [31:0]               vert_color;
  logic [LAYER_W-1:0]        vert_layer;
  logic signed [FIX_W-1:0]   pen_x;
  logic signed [FIX_W-1:0]   pen_y;
  logic                      last;

  modport source (output valid, quad_number, corner, vert_x, vert_y, tex_u, tex_v,
                  vert_color, vert_layer, pen_x, pen_y, last,
                  input ready);
  modport sink   (input valid, quad_number, corner, vert_x, vert_y, tex_u, tex_v,
                  vert_color, vert_layer, pen_x, pen_y, last,
                  output ready);
endinterface

interface gql_cfg_if import gql_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_W-1:0]      index;
  logic [CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/glyph_quad_layout.sv -----
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Bitmap font text layout: character codes in, textured quad vertices out.
// ----------------------------------------------------------------------------
// Load glyph metrics first (one request per table entry); an entry that was
// never loaded gives unspecified vertex values. Each visible character yields
// four vertex words (top-left, top-right, bottom-right, bottom-left) on the
// vtx channel while fewer than MAX_QUADS quads are placed; newline, load,
// clear and start-string requests yield none. The front sequencer takes a
// load, clear or start request in idle, steps a newline through multiply
// and sum, and a character through table read, multiply, sum and queue push.
// The back emits one vertex word per cycle while the receiver is ready, from
// a two-quad queue; the front takes no request until idle. Configuration words
// are taken every cycle and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_layout import gql_pkg::*; #(
  parameter int MAX_QUADS     = DEF_MAX_QUADS,
  parameter int GLYPH_ENTRIES = DEF_GLYPH_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst,
  gql_req_if.sink   req,
  gql_vtx_if.source vtx,
  gql_cfg_if.sink   cfg
);

  gql_cfg_t   cfg_regs;
  gql_quad_t  q_entry;
  gql_quad_t  q_head;
  gql_qstat_t qstat;
  logic       q_push;
  logic       q_pop;

  gql_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  gql_front #(
    .MAX_QUADS     (MAX_QUADS),
    .GLYPH_ENTRIES (GLYPH_ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg_regs),
    .qstat   (qstat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  gql_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_entry),
    .pop   (q_pop),
    .head  (q_head),
    .qstat (qstat)
  );

  gql_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .qstat (qstat),
    .cfg   (cfg_regs),
    .q_pop (q_pop),
    .vtx   (vtx)
  );

endmodule

`default_nettype wire

// ----- sv/gql_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gql_cfg_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gql_cfg_regs import gql_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  gql_cfg_if.sink   cfg,
  output gql_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_x         <= '0;
      regs.origin_y         <= '0;
      regs.glyph_scale      <= RST_GLYPH_SCALE;
      regs.inv_atlas_width  <= RST_INV_ATLAS;
      regs.inv_atlas_height <= RST_INV_ATLAS;
      regs.text_color       <= RST_TEXT_COLOR;
      regs.layer_value      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ORIGIN_X: regs.origin_x         <= cfg.data;
        CFG_ORIGIN_Y: regs.origin_y         <= cfg.data;
        CFG_SCALE:    regs.glyph_scale      <= cfg.data[SCALE_W-1:0];
        CFG_INV_W:    regs.inv_atlas_width  <= cfg.data[UV_W-1:0];
        CFG_INV_H:    regs.inv_atlas_height <= cfg.data[UV_W-1:0];
        CFG_COLOR:    regs.text_color       <= cfg.data;
        CFG_LAYER:    regs.layer_value      <= cfg.data[LAYER_W-1:0];
        default: ;  // unmapped index: drop the word
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/gql_front.sv -----
// ----------------------------------------------------------------------------
// gql_front
// Request side: glyph table, pen state and quad placement. A visible character
// runs through table read, multiply and sum steps and is pushed as one quad.
// ----------------------------------------------------------------------------
`default_nettype none

module gql_front import gql_pkg::*; #(
  parameter int MAX_QUADS     = DEF_MAX_QUADS,
  parameter int GLYPH_ENTRIES = DEF_GLYPH_ENTRIES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gql_req_if.sink         req,
  input  wire gql_cfg_t   cfg,
  input  wire gql_qstat_t qstat,
  output logic            q_push,
  output gql_quad_t       q_entry
);

  localparam int IDX_W = $clog2(GLYPH_ENTRIES);
  localparam int QC_W  = $clog2(MAX_QUADS + 1);

  gql_state_t state, state_next;

  logic [ENTRY_W-1:0] glyph_mem [GLYPH_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic               oob;
  logic               nl;

  logic [QC_W-1:0]    quad_count;
  logic [FIX_W-1:0]   pen_advance;
  logic [FIX_W-1:0]   pen_drop;

  logic signed [24:0] bx_s;
  logic signed [24:0] by_s;
  logic [23:0]        wq_s;
  logic [23:0]        hq_s;
  logic [23:0]        adv_s;
  logic [35:0]        u0_p;
  logic [35:0]        v0_p;
  logic [31:0]        du_p;
  logic [31:0]        dv_p;

  logic [FIX_W-1:0]   x0;
  logic [FIX_W-1:0]   y0;
  logic [UV_W-1:0]    u0;
  logic [UV_W-1:0]    v0;
  logic [UV_W-1:0]    u1;
  logic [UV_W-1:0]    v1;

  logic               accept;
  logic               in_range;
  logic               is_nl;
  logic               cap_full;
  logic [IDX_W-1:0]   idx;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] entry;
  logic signed [7:0]  bx;
  logic signed [7:0]  by;

  assign accept   = req.valid && req.ready;
  assign in_range = {1'b0, req.char_code} < (CODE_W + 1)'(GLYPH_ENTRIES);
  assign is_nl    = (req.char_code == NEWLINE_CODE);
  assign cap_full = (quad_count >= QC_W'(MAX_QUADS));
  assign idx      = req.char_code[IDX_W-1:0];
  assign wr_entry = {req.atlas_y, req.atlas_x, req.advance_px, req.bearing_y,
                     req.bearing_x, req.glyph_height, req.glyph_width};

  // a code past the table reads as an empty glyph
  assign entry = oob ? '0 : rd_data;
  assign bx    = entry[23:16];
  assign by    = entry[31:24];

  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_LOAD && in_range) begin
      glyph_mem[idx] <= wr_entry;
    end
    if (accept) begin
      rd_data <= glyph_mem[idx];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.req_type == REQ_CHAR && (is_nl || !cap_full)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = nl ? ST_IDLE : ST_PUSH;
      end
      ST_PUSH: begin
        // hold until the queue has room
        if (!qstat.full) begin
          q_push     = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // pen and quad counters
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_count  <= '0;
      pen_advance <= '0;
      pen_drop    <= '0;
    end else begin
      if (accept && req.req_type == REQ_CLEAR) begin
        quad_count <= '0;
      end else if (q_push) begin
        quad_count <= quad_count + 1'b1;
      end
      if (accept && req.req_type == REQ_START) begin
        pen_advance <= '0;
        pen_drop    <= '0;
      end else if (state == ST_SUM) begin
        if (nl) begin
          // drop by 1.5 scaled heights: hq*256 + hq*128
          pen_drop    <= sat32(ext32(pen_drop) + SUM_W'({hq_s, 8'd0})
                               + SUM_W'({hq_s, 7'd0}));
          pen_advance <= '0;
        end else begin
          pen_advance <= sat32(ext32(pen_advance) + SUM_W'({adv_s, 8'd0}));
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      oob <= !in_range;
      nl  <= is_nl;
    end
    if (state == ST_MUL) begin
      bx_s  <= bx * $signed({1'b0, cfg.glyph_scale});
      by_s  <= by * $signed({1'b0, cfg.glyph_scale});
      wq_s  <= entry[7:0] * cfg.glyph_scale;
      hq_s  <= entry[15:8] * cfg.glyph_scale;
      adv_s <= entry[39:32] * cfg.glyph_scale;
      u0_p  <= entry[51:40] * cfg.inv_atlas_width;
      v0_p  <= entry[63:52] * cfg.inv_atlas_height;
      du_p  <= entry[7:0] * cfg.inv_atlas_width;
      dv_p  <= entry[15:8] * cfg.inv_atlas_height;
    end
    if (state == ST_SUM) begin
      x0 <= sat32(ext32(cfg.origin_x) + ext32(pen_advance)
                  + {{(SUM_W-33){bx_s[24]}}, bx_s, 8'd0});
      y0 <= sat32(ext32(cfg.origin_y) + ext32(pen_drop)
                  - {{(SUM_W-33){by_s[24]}}, by_s, 8'd0});
      u0 <= sat24(UVSUM_W'(u0_p));
      v0 <= sat24(UVSUM_W'(v0_p));
      u1 <= sat24(UVSUM_W'(u0_p) + UVSUM_W'(du_p));
      v1 <= sat24(UVSUM_W'(v0_p) + UVSUM_W'(dv_p));
    end
  end

  always_comb begin
    q_entry.quad = QNUM_W'(quad_count);
    q_entry.x0   = x0;
    q_entry.y0   = y0;
    q_entry.x1   = sat32(ext32(x0) + SUM_W'({wq_s, 8'd0}));
    q_entry.y1   = sat32(ext32(y0) + SUM_W'({hq_s, 8'd0}));
    q_entry.u0   = u0;
    q_entry.v0   = v0;
    q_entry.u1   = u1;
    q_entry.v1   = v1;
    q_entry.px   = sat32(ext32(cfg.origin_x) + ext32(pen_advance));
    q_entry.py   = sat32(ext32(cfg.origin_y) + ext32(pen_drop));
  end

endmodule

`default_nettype wire

// ----- sv/gql_fifo.sv -----
// ----------------------------------------------------------------------------
// gql_fifo
// Short quad queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gql_fifo import gql_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire gql_quad_t din,
  input  wire logic      pop,
  output gql_quad_t      head,
  output gql_qstat_t     qstat
);

  gql_quad_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("quad queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("quad queue read while empty");

endmodule

`default_nettype wire

// ----- sv/gql_back.sv -----
// ----------------------------------------------------------------------------
// gql_back
// Vertex side: expands each queued quad into four corner words through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gql_back import gql_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire gql_quad_t  head,
  input  wire gql_qstat_t qstat,
  input  wire gql_cfg_t   cfg,
  output logic            q_pop,
  gql_vtx_if.source       vtx
);

  logic [1:0] corner_cnt;
  logic       out_valid;
  logic       load;
  logic       right;
  logic       bottom;

  assign load   = !qstat.empty && (!out_valid || vtx.ready);
  assign q_pop  = load && (corner_cnt == CORNER_BL);
  assign right  = (corner_cnt == CORNER_TR) || (corner_cnt == CORNER_BR);
  assign bottom = (corner_cnt == CORNER_BR) || (corner_cnt == CORNER_BL);

  assign vtx.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      corner_cnt <= CORNER_TL;
    end else if (load) begin
      out_valid  <= 1'b1;
      corner_cnt <= corner_cnt + 2'd1;
    end else if (vtx.ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vtx.quad_number <= head.quad;
      vtx.corner      <= corner_cnt;
      vtx.vert_x      <= right ? head.x1 : head.x0;
      vtx.vert_y      <= bottom ? head.y1 : head.y0;
      vtx.tex_u       <= right ? head.u1 : head.u0;
      vtx.tex_v       <= bottom ? head.v1 : head.v0;
      vtx.vert_color  <= cfg.text_color | ALPHA_FULL;
      vtx.vert_layer  <= cfg.layer_value;
      vtx.pen_x       <= head.px;
      vtx.pen_y       <= head.py;
      vtx.last        <= (corner_cnt == CORNER_BL);
    end
  end

  a_corner_step: assert property (@(posedge clk) disable iff (rst)
    (vtx.valid && vtx.ready && !vtx.last)
      |=> (vtx.valid && vtx.corner == $past(vtx.corner) + 2'd1))
    else $error("corner sequence broken inside a quad");

  a_quad_holds: assert property (@(posedge clk) disable iff (rst)
    (vtx.valid && vtx.ready && !vtx.last)
      |=> (vtx.quad_number == $past(vtx.quad_number)))
    else $error("quad number changed inside a quad");

  a_last_is_bl: assert property (@(posedge clk) disable iff (rst)
    (vtx.valid && q_pop) |-> (corner_cnt == CORNER_BL && $countones(vtx.corner) <= 2))
    else $error("queue entry released before its last corner");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for glyph_quad_layout. It loads glyph metrics, sends character,
// newline, clear and start-string requests, and checks every vertex word
// against a layout predictor kept inside the testbench. Directed tests
// cover the field extremes, each request type and saturation. Random
// phases follow, with register changes between them and random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gql_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     QUIET_CYCLES = 10;
  localparam int     END_CYCLES   = 20;
  localparam int     PHASES       = 6;
  localparam int     PHASE_ITEMS  = 50;
  localparam longint Q16_MAX      = 64'sd2147483647;
  localparam longint Q16_MIN      = -64'sd2147483648;
  localparam longint UV_MAX       = 64'sd16777215;

  typedef struct {
    gql_req_t           kind;
    logic [CODE_W-1:0]  code;
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [7:0]  bear_x;
    logic signed [7:0]  bear_y;
    logic [7:0]         advance;
    logic [ATLAS_W-1:0] atlas_x;
    logic [ATLAS_W-1:0] atlas_y;
  } text_request_t;

  typedef struct {
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [7:0]  bear_x;
    logic signed [7:0]  bear_y;
    logic [7:0]         advance;
    logic [ATLAS_W-1:0] atlas_x;
    logic [ATLAS_W-1:0] atlas_y;
  } glyph_metrics_t;

  typedef struct {
    logic [QNUM_W-1:0]  quad;
    logic [1:0]         corner;
    logic [FIX_W-1:0]   x;
    logic [FIX_W-1:0]   y;
    logic [UV_W-1:0]    u;
    logic [UV_W-1:0]    v;
    logic [31:0]        color;
    logic [LAYER_W-1:0] layer;
    logic [FIX_W-1:0]   pen_x;
    logic [FIX_W-1:0]   pen_y;
    logic               last;
  } vertex_word_t;

  typedef struct {
    gql_cfg_idx_t          idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gql_req_if req_ch ();
  gql_vtx_if vtx_ch ();
  gql_cfg_if cfg_ch ();

  glyph_quad_layout dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .vtx (vtx_ch),
    .cfg (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // layout state as the block should hold it
  logic signed [FIX_W-1:0] origin_x_reg = '0;
  logic signed [FIX_W-1:0] origin_y_reg = '0;
  logic [SCALE_W-1:0]      scale_reg    = RST_GLYPH_SCALE;
  logic [UV_W-1:0]         inv_w_reg    = RST_INV_ATLAS;
  logic [UV_W-1:0]         inv_h_reg    = RST_INV_ATLAS;
  logic [31:0]             color_reg    = RST_TEXT_COLOR;
  logic [LAYER_W-1:0]      layer_reg    = '0;

  glyph_metrics_t          glyph_rom    [DEF_GLYPH_ENTRIES];
  bit                      glyph_loaded [DEF_GLYPH_ENTRIES];
  int                      quads_placed = 0;
  logic signed [FIX_W-1:0] pen_adv      = '0;
  logic signed [FIX_W-1:0] pen_drop     = '0;

  vertex_word_t expected_vertices [$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int unsigned  send_gap_max   = 9;
  int unsigned  drain_gap_max  = 9;

  function automatic logic signed [FIX_W-1:0] clamp_q16(longint v);
    if (v > Q16_MAX) return 32'sh7FFF_FFFF;
    if (v < Q16_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic logic [UV_W-1:0] clamp_uv(longint v);
    return (v > UV_MAX) ? 24'hFF_FFFF : 24'(v);
  endfunction

  // place one character, or move the pen for a newline
  function automatic void place_glyph(logic [CODE_W-1:0] code);
    glyph_metrics_t g;
    vertex_word_t   w;
    longint         sc;
    longint         x0, y0, x1, y1, u0, v0, u1, v1;
    logic signed [FIX_W-1:0] px, py;
    g  = glyph_rom[code];
    sc = longint'(scale_reg);
    if (code == NEWLINE_CODE) begin
      pen_drop = clamp_q16(longint'(pen_drop) + longint'(g.height) * sc * 384);
      pen_adv  = '0;
      return;
    end
    if (quads_placed >= DEF_MAX_QUADS) return;
    x0 = clamp_q16(longint'(origin_x_reg) + longint'(pen_adv)
                   + longint'(g.bear_x) * sc * 256);
    y0 = clamp_q16(longint'(origin_y_reg) + longint'(pen_drop)
                   - longint'(g.bear_y) * sc * 256);
    x1 = clamp_q16(x0 + longint'(g.width) * sc * 256);
    y1 = clamp_q16(y0 + longint'(g.height) * sc * 256);
    u0 = longint'(g.atlas_x) * longint'(inv_w_reg);
    v0 = longint'(g.atlas_y) * longint'(inv_h_reg);
    u1 = clamp_uv(u0 + longint'(g.width) * longint'(inv_w_reg));
    v1 = clamp_uv(v0 + longint'(g.height) * longint'(inv_h_reg));
    u0 = clamp_uv(u0);
    v0 = clamp_uv(v0);
    pen_adv = clamp_q16(longint'(pen_adv) + longint'(g.advance) * sc * 256);
    px = clamp_q16(longint'(origin_x_reg) + longint'(pen_adv));
    py = clamp_q16(longint'(origin_y_reg) + longint'(pen_drop));
    for (int k = 0; k < 4; k++) begin
      w.corner = 2'(k);
      w.quad   = QNUM_W'(quads_placed);
      w.x      = (w.corner == CORNER_TR || w.corner == CORNER_BR) ? 32'(x1) : 32'(x0);
      w.y      = (w.corner == CORNER_BR || w.corner == CORNER_BL) ? 32'(y1) : 32'(y0);
      w.u      = (w.corner == CORNER_TR || w.corner == CORNER_BR) ? 24'(u1) : 24'(u0);
      w.v      = (w.corner == CORNER_BR || w.corner == CORNER_BL) ? 24'(v1) : 24'(v0);
      w.color  = color_reg | ALPHA_FULL;
      w.layer  = layer_reg;
      w.pen_x  = px;
      w.pen_y  = py;
      w.last   = (w.corner == CORNER_BL);
      expected_vertices.push_back(w);
    end
    quads_placed++;
  endfunction

  function automatic void apply_request(text_request_t r);
    case (r.kind)
      REQ_LOAD: begin
        glyph_rom[r.code] = '{r.width, r.height, r.bear_x, r.bear_y, r.advance,
                              r.atlas_x, r.atlas_y};
        glyph_loaded[r.code] = 1'b1;
      end
      REQ_CHAR:  place_glyph(r.code);
      REQ_CLEAR: quads_placed = 0;
      REQ_START: begin
        pen_adv  = '0;
        pen_drop = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_register(gql_cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ORIGIN_X: origin_x_reg = d;
      CFG_ORIGIN_Y: origin_y_reg = d;
      CFG_SCALE:    scale_reg    = d[SCALE_W-1:0];
      CFG_INV_W:    inv_w_reg    = d[UV_W-1:0];
      CFG_INV_H:    inv_h_reg    = d[UV_W-1:0];
      CFG_COLOR:    color_reg    = d;
      CFG_LAYER:    layer_reg    = d[LAYER_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic text_request_t make_request(gql_req_t kind, logic [7:0] code,
      logic [7:0] gw, logic [7:0] gh, logic signed [7:0] bx, logic signed [7:0] by,
      logic [7:0] adv, logic [11:0] ax, logic [11:0] ay);
    return '{kind, code, gw, gh, bx, by, adv, ax, ay};
  endfunction

  // metric fields are random; the block ignores them except on a load
  function automatic text_request_t random_request(gql_req_t kind, logic [7:0] code);
    return make_request(kind, code, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                        8'($urandom()), 8'($urandom()), 12'($urandom()),
                        12'($urandom()));
  endfunction

  // any loaded entry; newline included when it comes up
  function automatic logic [7:0] pick_loaded_code();
    logic [7:0] code;
    do code = 8'($urandom_range(0, DEF_GLYPH_ENTRIES - 1)); while (!glyph_loaded[code]);
    return code;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_register_value(gql_cfg_idx_t idx);
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return $urandom();
    case (idx)
      CFG_ORIGIN_X, CFG_ORIGIN_Y: begin
        if (pick == 1) return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        return (pick == 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      CFG_SCALE: begin
        if (pick == 1) return 32'($urandom_range(64, 1024));
        return (pick == 2) ? 32'h0 : 32'h0000_FFFF;
      end
      CFG_INV_W, CFG_INV_H: begin
        if (pick == 1) return 32'($urandom_range(1024, 65536));
        return (pick == 2) ? 32'h0 : 32'h00FF_FFFF;
      end
      default: return (pick == 2) ? 32'h0 : 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_request(text_request_t r);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.kind;
    req_ch.char_code    <= r.code;
    req_ch.glyph_width  <= r.width;
    req_ch.glyph_height <= r.height;
    req_ch.bearing_x    <= r.bear_x;
    req_ch.bearing_y    <= r.bear_y;
    req_ch.advance_px   <= r.advance;
    req_ch.atlas_x      <= r.atlas_x;
    req_ch.atlas_y      <= r.atlas_y;
    do @(posedge clk); while (!req_ch.ready);
    apply_request(r);
  endtask

  // drop valid, drain every expected word, then cover the silent requests
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(reg_write_t writes[$]);
    settle();
    foreach (writes[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= writes[i].idx;
      cfg_ch.data  <= writes[i].data;
      do @(posedge clk); while (!cfg_ch.ready);
      apply_register(writes[i].idx, writes[i].data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_char(logic [7:0] code);
    send_request(random_request(REQ_CHAR, code));
  endtask

  task automatic test_glyph_extremes();
    send_request(make_request(REQ_LOAD, NEWLINE_CODE, 8, 16, 0, 12, 9, 16, 0));
    send_request(make_request(REQ_LOAD, 8'd0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_LOAD, 8'd255, 255, 255, -128, 127, 255, 4095, 4095));
    send_request(make_request(REQ_LOAD, 8'd128, 0, 0, 127, -128, 0, 2048, 1024));
    send_request(make_request(REQ_LOAD, 8'd65, 10, 14, 1, 12, 11, 100, 200));
    send_char(8'd0);
    send_char(8'd255);
    send_char(8'd128);
    send_char(NEWLINE_CODE);
    send_char(8'd65);
  endtask

  task automatic test_operations();
    send_request(random_request(REQ_START, 8'($urandom())));
    send_char(8'd65);
    // quad numbering restarts after a clear, the pen does not
    send_request(random_request(REQ_CLEAR, 8'($urandom())));
    send_char(8'd255);
    send_char(NEWLINE_CODE);
    send_char(NEWLINE_CODE);
    send_request(random_request(REQ_START, 8'($urandom())));
    send_char(8'd65);
  endtask

  task automatic test_saturation();
    program_registers('{'{CFG_ORIGIN_X, 32'h7FFF_FFFF}, '{CFG_ORIGIN_Y, 32'h8000_0000},
                        '{CFG_SCALE, 32'h0000_FFFF}, '{CFG_INV_W, 32'h00FF_FFFF},
                        '{CFG_INV_H, 32'h00FF_FFFF}, '{CFG_COLOR, 32'h0},
                        '{CFG_LAYER, 32'h0000_FFFF}});
    send_request(random_request(REQ_START, 8'($urandom())));
    send_char(8'd255);
    send_char(8'd128);
    send_char(NEWLINE_CODE);
    send_char(8'd255);
    program_registers('{'{CFG_ORIGIN_X, 32'h8000_0000}, '{CFG_ORIGIN_Y, 32'h7FFF_FFFF},
                        '{CFG_SCALE, 32'h0}, '{CFG_INV_W, 32'h0}, '{CFG_INV_H, 32'h0},
                        '{CFG_COLOR, 32'hFFFF_FFFF}, '{CFG_LAYER, 32'h0}});
    send_char(8'd255);
    send_char(8'd128);
    program_registers('{'{CFG_ORIGIN_X, 32'h0010_0000}, '{CFG_ORIGIN_Y, 32'h0020_0000},
                        '{CFG_SCALE, 32'h0000_0180}, '{CFG_INV_W, 32'h0000_1000},
                        '{CFG_INV_H, 32'h0000_2000}, '{CFG_COLOR, 32'h4080_C000},
                        '{CFG_LAYER, 32'h0000_0007}});
  endtask

  task automatic test_random();
    reg_write_t   writes [$];
    gql_cfg_idx_t idx;
    int unsigned  r;
    for (int p = 0; p < PHASES; p++) begin
      writes = {};
      repeat ($urandom_range(1, 3)) begin
        idx = gql_cfg_idx_t'($urandom_range(CFG_ORIGIN_X, CFG_LAYER));
        writes.push_back('{idx, random_register_value(idx)});
      end
      program_registers(writes);
      send_gap_max  = (p == 2 || p == 4) ? 0 : 9;
      drain_gap_max = (p == 2) ? 0 : 9;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12) send_request(random_request(REQ_LOAD, 8'($urandom())));
        else if (r < 15) send_request(random_request(REQ_CLEAR, 8'($urandom())));
        else if (r < 19) send_request(random_request(REQ_START, 8'($urandom())));
        else if (r < 27) send_char(NEWLINE_CODE);
        else send_char(pick_loaded_code());
      end
    end
  endtask

  // receiver: random stall before each vertex word
  initial begin : vertex_drain
    int unsigned pause;
    vtx_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      pause = $urandom_range(0, drain_gap_max);
      if (pause != 0) begin
        vtx_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      vtx_ch.ready <= 1'b1;
      do @(posedge clk); while (!(vtx_ch.valid && vtx_ch.ready));
    end
  end

  always @(posedge clk) begin : vertex_check
    vertex_word_t want;
    if (!rst && vtx_ch.valid && vtx_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex word with none expected: quad %0d corner %0d",
               vtx_ch.quad_number, vtx_ch.corner);
        mismatch_count++;
      end else begin
        want = expected_vertices.pop_front();
        compare_field("quad_number", want.quad, vtx_ch.quad_number);
        compare_field("corner", want.corner, vtx_ch.corner);
        compare_field("vert_x", want.x, vtx_ch.vert_x);
        compare_field("vert_y", want.y, vtx_ch.vert_y);
        compare_field("tex_u", want.u, vtx_ch.tex_u);
        compare_field("tex_v", want.v, vtx_ch.tex_v);
        compare_field("vert_color", want.color, vtx_ch.vert_color);
        compare_field("vert_layer", want.layer, vtx_ch.vert_layer);
        compare_field("pen_x", want.pen_x, vtx_ch.pen_x);
        compare_field("pen_y", want.pen_y, vtx_ch.pen_y);
        compare_field("last", want.last, vtx_ch.last);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("glyph_quad_layout test failed");
    $finish;
  end

  initial begin : run
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOAD;
    req_ch.char_code    = '0;
    req_ch.glyph_width  = '0;
    req_ch.glyph_height = '0;
    req_ch.bearing_x    = '0;
    req_ch.bearing_y    = '0;
    req_ch.advance_px   = '0;
    req_ch.atlas_x      = '0;
    req_ch.atlas_y      = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_ORIGIN_X;
    cfg_ch.data         = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_glyph_extremes();
    test_operations();
    test_saturation();
    test_random();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_vertices.size() == 0) begin
      $display("glyph_quad_layout test passed");
    end else begin
      $display("glyph_quad_layout test failed");
    end
    $finish;
  end

endmodule
